@@ hdl/vwalu_pkg.sv @@
`default_nettype none

package vwalu_pkg;

    // Port widths fixed by the interface
    localparam int DATA_BITS = 32;
    localparam int FUNC_BITS = 5;
    localparam int WS_BITS   = 6;

    // Default for the top-level MAX_WIDTH parameter
    localparam int DEFAULT_MAX_WIDTH = 32;

    // Word size after reset
    localparam logic [WS_BITS-1:0] WS_RESET = 6'd8;

    // Operation codes
    typedef enum logic [FUNC_BITS-1:0] {
        FN_PASS = 5'd0,
        FN_NOT  = 5'd1,
        FN_LNOT = 5'd2,
        FN_NEG  = 5'd3,
        FN_XOR  = 5'd4,
        FN_AND  = 5'd5,
        FN_OR   = 5'd6,
        FN_LAND = 5'd7,
        FN_LOR  = 5'd8,
        FN_ADD  = 5'd9,
        FN_SUB  = 5'd10,
        FN_MUL  = 5'd11,
        FN_SHL  = 5'd12,
        FN_SHR  = 5'd13,
        FN_EQ   = 5'd14,
        FN_LE   = 5'd15,
        FN_LT   = 5'd16,
        FN_GE   = 5'd17,
        FN_GT   = 5'd18
    } func_t;

    // Control that travels with an item out of the execute stage
    typedef struct packed {
        logic valid;        // item present
        logic flags_valid;  // add, sub, and, xor
        logic add_sub;      // carry and overflow are meaningful
        logic a_top;        // operand a, bit word_size-1
        logic bb_top;       // effective addend, bit word_size-1
    } ctrl_t;

    // Low w bits set; w never exceeds 63
    function automatic logic [63:0] width_mask(input logic [WS_BITS-1:0] w);
        width_mask = (64'd1 << w) - 64'd1;
    endfunction

endpackage

`default_nettype wire

@@ hdl/variable_width_alu_with_flags.sv @@
// Variable-width ALU with condition flags, three register stages.
// done follows start through the stage-1, execute and output registers.
// Throughput: one operation per cycle; busy is always low and the receiver
// cannot stall, so each result is shown for exactly one cycle.
// Reset (rst_n, async low) empties the pipeline and sets word size to 8.
`default_nettype none

module variable_width_alu_with_flags #(
    parameter int MAX_WIDTH = vwalu_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [vwalu_pkg::FUNC_BITS-1:0]     func,
    input  wire logic [vwalu_pkg::DATA_BITS-1:0]     operand_a,
    input  wire logic [vwalu_pkg::DATA_BITS-1:0]     operand_b,
    input  wire logic                                cfg_wr_en,
    input  wire logic [vwalu_pkg::WS_BITS-1:0]       cfg_wr_data,
    output logic                                     done,
    output logic [vwalu_pkg::DATA_BITS-1:0]          result,
    output logic                                     carry_flag,
    output logic                                     zero_flag,
    output logic                                     sign_flag,
    output logic                                     overflow_flag,
    output logic                                     flags_valid
);

    localparam int DW = MAX_WIDTH;
    localparam int WB = vwalu_pkg::WS_BITS;

    logic [WB-1:0]                      word_size_reg;
    logic [WB-1:0]                      word_size_next;
    logic                               accept;

    logic                               s1_valid_reg;
    vwalu_pkg::func_t                   s1_func_reg;
    logic [DW-1:0]                      s1_a_reg;
    logic [DW-1:0]                      s1_b_reg;
    logic [WB-1:0]                      s1_ws_reg;
    logic [DW-1:0]                      mask1;

    vwalu_pkg::ctrl_t                   s2_ctrl;
    logic [DW:0]                        s2_res;
    logic [WB-1:0]                      s2_ws;

    logic [DW-1:0]                      mask3;
    logic [DW-1:0]                      r3;
    logic [DW:0]                        carry_sh;
    logic [DW-1:0]                      r3_sh;
    logic                               sf_raw;
    logic                               of_raw;

    logic                               done_reg;
    logic [vwalu_pkg::DATA_BITS-1:0]    result_reg;
    logic                               carry_reg;
    logic                               zero_reg;
    logic                               sign_reg;
    logic                               overflow_reg;
    logic                               fv_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Word size register; out-of-range writes are dropped
    always_comb
    begin
        word_size_next = word_size_reg;
        if (cfg_wr_en && (cfg_wr_data != '0)
            && ({1'b0, cfg_wr_data} <= (WB+1)'(MAX_WIDTH)))
        begin
            word_size_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_size_reg <= vwalu_pkg::WS_RESET;
        end
        else
        begin
            word_size_reg <= word_size_next;
        end
    end

    // Stage 1: mask operands to the word size
    assign mask1 = DW'(vwalu_pkg::width_mask(word_size_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= vwalu_pkg::func_t'(func);
            s1_a_reg    <= DW'(operand_a) & mask1;
            s1_b_reg    <= DW'(operand_b) & mask1;
            s1_ws_reg   <= word_size_reg;
        end
    end

    // Stage 2: execute
    vwalu_exec #(
        .DW (DW)
    ) u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid_reg),
        .in_func  (s1_func_reg),
        .in_a     (s1_a_reg),
        .in_b     (s1_b_reg),
        .in_ws    (s1_ws_reg),
        .out_ctrl (s2_ctrl),
        .out_res  (s2_res),
        .out_ws   (s2_ws)
    );

    // Stage 3: mask result, derive flags
    assign mask3    = DW'(vwalu_pkg::width_mask(s2_ws));
    assign r3       = s2_res[DW-1:0] & mask3;
    assign carry_sh = s2_res >> s2_ws;
    assign r3_sh    = r3 >> (s2_ws - WB'(1));
    assign sf_raw   = r3_sh[0];
    assign of_raw   = (s2_ctrl.a_top ^ sf_raw) & (s2_ctrl.bb_top ^ sf_raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg   <= vwalu_pkg::DATA_BITS'(r3);
        carry_reg    <= s2_ctrl.add_sub && carry_sh[0];
        overflow_reg <= s2_ctrl.add_sub && of_raw;
        zero_reg     <= s2_ctrl.flags_valid && (r3 == '0);
        sign_reg     <= s2_ctrl.flags_valid && sf_raw;
        fv_reg       <= s2_ctrl.flags_valid;
    end

    assign done          = done_reg;
    assign result        = result_reg;
    assign carry_flag    = carry_reg;
    assign zero_flag     = zero_reg;
    assign sign_flag     = sign_reg;
    assign overflow_flag = overflow_reg;
    assign flags_valid   = fv_reg;

    // Checks
    a_ws_range: assert property (@(posedge clk) disable iff (!rst_n)
        (word_size_reg != '0) && ({1'b0, word_size_reg} <= (WB+1)'(MAX_WIDTH)))
        else $error("word size out of range");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("result without a start three cycles earlier");

    a_flags_gated: assert property (@(posedge clk) disable iff (!rst_n)
        done && (carry_flag || overflow_flag || zero_flag || sign_flag) |-> flags_valid)
        else $error("flag set on an operation without flags");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_flag |-> (result == '0))
        else $error("zero flag with nonzero result");

endmodule

`default_nettype wire

@@ hdl/vwalu_exec.sv @@
`default_nettype none

// Execute stage: adder, logic and shift unit, compares and the low half
// of the multiplier, all registered at the stage boundary.
module vwalu_exec #(
    parameter int DW = vwalu_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire vwalu_pkg::func_t                  in_func,
    input  wire logic [DW-1:0]                     in_a,
    input  wire logic [DW-1:0]                     in_b,
    input  wire logic [vwalu_pkg::WS_BITS-1:0]     in_ws,
    output vwalu_pkg::ctrl_t                       out_ctrl,
    output logic [DW:0]                            out_res,
    output logic [vwalu_pkg::WS_BITS-1:0]          out_ws
);

    localparam int MB = vwalu_pkg::DATA_BITS;

    logic [DW-1:0]                     mask;
    logic [DW-1:0]                     bb;
    logic [DW:0]                       sum;
    logic [MB-1:0]                     mul_a;
    logic [MB-1:0]                     mul_b;
    logic [MB-1:0]                     prod;
    logic [DW-1:0]                     a_sh;
    logic [DW-1:0]                     bb_sh;
    logic [DW-1:0]                     res_d;
    logic                              is_addsub;
    logic                              is_flag;
    vwalu_pkg::ctrl_t                  ctrl_next;
    logic [DW:0]                       res_next;

    vwalu_pkg::ctrl_t                  ctrl_reg;
    logic [DW:0]                       res_reg;
    logic [vwalu_pkg::WS_BITS-1:0]     ws_reg;

    // Subtract adds the masked two's-complement negation of b
    assign mask = DW'(vwalu_pkg::width_mask(in_ws));
    assign bb   = (in_func == vwalu_pkg::FN_SUB) ? ((~in_b + DW'(1)) & mask) : in_b;
    assign sum  = {1'b0, in_a} + {1'b0, bb};

    // Only the low word of the product ever reaches the result port
    assign mul_a = MB'(in_a);
    assign mul_b = MB'(in_b);
    assign prod  = mul_a * mul_b;

    // Top bits of both addends, for the overflow term
    assign a_sh  = in_a >> (in_ws - vwalu_pkg::WS_BITS'(1));
    assign bb_sh = bb >> (in_ws - vwalu_pkg::WS_BITS'(1));

    assign is_addsub = (in_func == vwalu_pkg::FN_ADD) || (in_func == vwalu_pkg::FN_SUB);
    assign is_flag   = is_addsub || (in_func == vwalu_pkg::FN_AND)
                    || (in_func == vwalu_pkg::FN_XOR);

    // Operation select; masking happens in the next stage
    always_comb
    begin
        case (in_func)
            vwalu_pkg::FN_PASS: res_d = in_a;
            vwalu_pkg::FN_NOT:  res_d = ~in_a;
            vwalu_pkg::FN_LNOT: res_d = DW'(in_a == '0);
            vwalu_pkg::FN_NEG:  res_d = '0 - in_a;
            vwalu_pkg::FN_XOR:  res_d = in_a ^ in_b;
            vwalu_pkg::FN_AND:  res_d = in_a & in_b;
            vwalu_pkg::FN_OR:   res_d = in_a | in_b;
            vwalu_pkg::FN_LAND: res_d = DW'((in_a != '0) && (in_b != '0));
            vwalu_pkg::FN_LOR:  res_d = DW'((in_a != '0) || (in_b != '0));
            vwalu_pkg::FN_ADD:  res_d = sum[DW-1:0];
            vwalu_pkg::FN_SUB:  res_d = sum[DW-1:0];
            vwalu_pkg::FN_MUL:  res_d = DW'(prod);
            vwalu_pkg::FN_SHL:  res_d = in_a << in_b;
            vwalu_pkg::FN_SHR:  res_d = in_a >> in_b;
            vwalu_pkg::FN_EQ:   res_d = DW'(in_a == in_b);
            vwalu_pkg::FN_LE:   res_d = DW'(in_a <= in_b);
            vwalu_pkg::FN_LT:   res_d = DW'(in_a < in_b);
            vwalu_pkg::FN_GE:   res_d = DW'(in_a >= in_b);
            vwalu_pkg::FN_GT:   res_d = DW'(in_a > in_b);
            default:            res_d = '0;
        endcase
    end

    // Add/sub keeps the carry bit above the data word
    always_comb
    begin
        res_next              = is_addsub ? sum : {1'b0, res_d};
        ctrl_next.valid       = in_valid;
        ctrl_next.flags_valid = is_flag;
        ctrl_next.add_sub     = is_addsub;
        ctrl_next.a_top       = a_sh[0];
        ctrl_next.bb_top      = bb_sh[0];
    end

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        ws_reg  <= in_ws;
    end

    assign out_ctrl = ctrl_reg;
    assign out_res  = res_reg;
    assign out_ws   = ws_reg;

endmodule

`default_nettype wire
